// File: sv/msfd_pkg.sv
// ----------------------------------------------------------------------------
// msfd_pkg: shared types and constants for the multi-session frame deframer
// Beat payload structs, parse phases, result kinds and sync byte values.
// ----------------------------------------------------------------------------
package msfd_pkg;

    localparam int SESSIONS = 16;
    localparam int IDX_W    = (SESSIONS > 1) ? $clog2(SESSIONS) : 1;

    localparam logic [7:0] SYNC_FIRST  = 8'hFE;
    localparam logic [7:0] SYNC_SECOND = 8'hEF;

    localparam logic OP_BYTE  = 1'b0;
    localparam logic OP_ABORT = 1'b1;

    typedef enum logic [2:0] {
        PH_HUNT   = 3'd0,
        PH_SYNC2  = 3'd1,
        PH_OLEN_H = 3'd2,
        PH_OLEN_L = 3'd3,
        PH_OPTION = 3'd4,
        PH_DLEN_H = 3'd5,
        PH_DLEN_L = 3'd6,
        PH_DATA   = 3'd7
    } t_phase;

    typedef enum logic [1:0] {
        KIND_OPTION = 2'd0,
        KIND_DATA   = 2'd1,
        KIND_EMPTY  = 2'd2
    } t_kind;

    typedef struct packed {
        logic       op;
        logic [3:0] session;
        logic [7:0] rx_byte;
    } t_in;

    typedef struct packed {
        logic [3:0] out_session;
        logic [7:0] payload_byte;
        logic [1:0] kind;
        logic       frame_end;
    } t_out;

    // Per-session context held in the state memory.
    typedef struct packed {
        t_phase      phase;
        logic [15:0] remaining;
        logic [7:0]  len_hi;
    } t_entry;

endpackage

// File: sv/multi_session_frame_deframer.sv
// ----------------------------------------------------------------------------
// multi_session_frame_deframer
// Length-prefixed frame parser with one context per session, kept in a
// single-port-write, registered-read state memory.
// ----------------------------------------------------------------------------
// Path: a result beat passes through the memory read register, then is updated
// into the output register; a stalled output holds it back in between.
// Throughput: one beat per cycle while the output is not stalled, any mix of sessions; the back-to-back
// read-after-write on one session is covered by forwarding the last write.
// Reset: synchronous, active low; per-entry valid flags make every session
// read as hunting with zero counts, so no clearing pass is needed.
module multi_session_frame_deframer (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  msfd_pkg::t_in i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output msfd_pkg::t_out o_out_data
);
    import msfd_pkg::*;

    t_entry r_mem [SESSIONS];
    t_entry r_rd;
    logic [SESSIONS-1:0] r_vbits;

    logic             r_s1_vld;
    logic [IDX_W-1:0] r_s1_idx;
    t_in              r_s1_in;

    logic             r_wr_vld;
    logic [IDX_W-1:0] r_wr_idx;
    t_entry           r_wr_data;

    logic r_out_vld;
    t_out r_out;

    logic [7:0]       sess_ext;
    logic [IDX_W-1:0] in_idx;
    logic             in_range;
    logic             in_acc;
    logic             s1_adv;
    logic             wr_en;
    t_entry           cur;
    t_entry           nxt;
    logic [15:0]      rem_dec;
    logic [15:0]      len_full;
    logic             emit;
    t_out             res;

    assign sess_ext = 8'(i_in_data.session);
    assign in_idx   = sess_ext[IDX_W-1:0];
    assign in_range = 9'(i_in_data.session) < 9'(SESSIONS);

    assign s1_adv     = r_s1_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall = r_s1_vld && !s1_adv;
    assign in_acc     = i_in_valid && !o_in_stall;
    assign wr_en      = s1_adv;

    // Current context: last write wins, then memory, then reset value.
    always_comb begin
        if (r_wr_vld && (r_wr_idx == r_s1_idx)) begin
            cur = r_wr_data;
        end else if (r_vbits[r_s1_idx]) begin
            cur = r_rd;
        end else begin
            cur = '{phase: PH_HUNT, remaining: 16'd0, len_hi: 8'd0};
        end
    end

    assign rem_dec  = cur.remaining - 16'd1;
    assign len_full = {cur.len_hi, r_s1_in.rx_byte};

    always_comb begin
        nxt  = cur;
        emit = 1'b0;
        res  = '{out_session: r_s1_in.session, payload_byte: r_s1_in.rx_byte,
                 kind: KIND_OPTION, frame_end: 1'b0};
        if (r_s1_in.op == OP_ABORT) begin
            nxt = '{phase: PH_HUNT, remaining: 16'd0, len_hi: 8'd0};
        end else begin
            unique case (cur.phase)
                PH_HUNT: begin
                    if (r_s1_in.rx_byte == SYNC_FIRST) nxt.phase = PH_SYNC2;
                end
                PH_SYNC2: begin
                    nxt.phase = (r_s1_in.rx_byte == SYNC_SECOND) ? PH_OLEN_H : PH_HUNT;
                end
                PH_OLEN_H, PH_DLEN_H: begin
                    nxt.len_hi = r_s1_in.rx_byte;
                    nxt.phase  = (cur.phase == PH_OLEN_H) ? PH_OLEN_L : PH_DLEN_L;
                end
                PH_OLEN_L: begin
                    nxt.remaining = len_full;
                    nxt.phase     = (len_full != 16'd0) ? PH_OPTION : PH_DLEN_H;
                end
                PH_OPTION: begin
                    nxt.remaining = rem_dec;
                    if (rem_dec == 16'd0) nxt.phase = PH_DLEN_H;
                    emit = 1'b1;
                end
                PH_DLEN_L: begin
                    nxt.remaining = len_full;
                    if (len_full == 16'd0) begin
                        nxt.phase        = PH_HUNT;
                        emit             = 1'b1;
                        res.payload_byte = 8'd0;
                        res.kind         = KIND_EMPTY;
                        res.frame_end    = 1'b1;
                    end else begin
                        nxt.phase = PH_DATA;
                    end
                end
                PH_DATA: begin
                    nxt.remaining = rem_dec;
                    emit          = 1'b1;
                    res.kind      = KIND_DATA;
                    if (rem_dec == 16'd0) begin
                        nxt.phase     = PH_HUNT;
                        res.frame_end = 1'b1;
                    end
                end
                default: nxt = cur;
            endcase
        end
    end

    // State memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_s1_idx] <= nxt;
        end
        if (in_acc) begin
            r_rd <= r_mem[in_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vbits   <= '0;
            r_s1_vld  <= 1'b0;
            r_wr_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (wr_en) begin
                r_vbits[r_s1_idx] <= 1'b1;
            end
            if (in_acc) begin
                r_s1_vld <= in_range;
                r_wr_vld <= wr_en;
            end else if (s1_adv) begin
                r_s1_vld <= 1'b0;
            end
            if (s1_adv && emit) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_idx  <= in_idx;
            r_s1_in   <= i_in_data;
            r_wr_idx  <= r_s1_idx;
            r_wr_data <= nxt;
        end
        if (s1_adv && emit) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

// File: sv/msfd_checker.sv
// ----------------------------------------------------------------------------
// msfd_checker: port-level checks for the multi-session frame deframer
// Watches the input handshake and the output beats over time and is bound to the top level.
// ----------------------------------------------------------------------------
module msfd_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           o_in_stall,
    input msfd_pkg::t_in  i_in_data,
    input logic           o_out_valid,
    input logic           i_out_stall,
    input msfd_pkg::t_out o_out_data
);
    import msfd_pkg::*;

    // A stalled result beat stays offered and unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result beat dropped or changed");

    // Nothing comes out in the cycle after a reset.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result beat right after reset");

    // An empty-frame marker always closes the frame with a zero byte.
    a_empty_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.kind == KIND_EMPTY)
        |-> o_out_data.frame_end && (o_out_data.payload_byte == 8'd0))
        else $error("malformed empty-frame marker");

    // Option bytes never end a frame, and no unused kind appears.
    a_kind_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.kind == KIND_DATA || o_out_data.kind == KIND_EMPTY
        || (o_out_data.kind == KIND_OPTION && !o_out_data.frame_end)))
        else $error("illegal kind or frame end on option byte");

    // With no beat accepted and nothing held across the antecedent, no result can appear.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid && !(i_in_valid && !o_in_stall)
        ##1 !o_out_valid && !(i_in_valid && !o_in_stall)
        |=> !o_out_valid)
        else $error("result beat with no input behind it");

endmodule

bind multi_session_frame_deframer msfd_checker u_msfd_checker (.*);
